// ===== rtl/u8d_pkg.sv =====
package u8d_pkg;

    localparam int unsigned CP_W     = 31;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned REM_W    = 3;
    localparam int unsigned CLASS_W  = 3;
    localparam int unsigned Q_DEPTH  = 3;
    localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [CP_W-1:0] REPLACEMENT   = 31'd65533;
    localparam logic [CP_W-1:0] SURROGATE_LO  = 31'd55296;
    localparam logic [CP_W-1:0] SURROGATE_HI  = 31'd57343;

    // sequence classes: none open, then lead bytes for 2..6 byte forms
    localparam logic [CLASS_W-1:0] CLASS_NONE = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_2B   = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_3B   = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_4B   = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_5B   = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_6B   = 3'd5;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad_flag;
        logic            last_of_run;
    } result_t;

    // smallest legal value per sequence class
    function automatic logic [CP_W-1:0] class_min(input logic [CLASS_W-1:0] cls);
        logic [CP_W-1:0] m;
        case (cls)
            CLASS_2B: m = 31'd128;
            CLASS_3B: m = 31'd2048;
            CLASS_4B: m = 31'd65536;
            CLASS_5B: m = 31'd2097152;
            CLASS_6B: m = 31'd67108864;
            default:  m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/u8d_if.sv =====
interface u8d_byte_if;
    logic                          valid;
    logic                          ready;
    logic [u8d_pkg::BYTE_W-1:0]    byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8d_result_if;
    logic                          valid;
    logic                          ready;
    logic [u8d_pkg::CP_W-1:0]      code_point;
    logic                          bad_flag;
    logic                          last_of_run;

    modport source (output valid, output code_point, output bad_flag,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input bad_flag,
                    input last_of_run, output ready);
endinterface

// ===== rtl/utf8_stream_decoder_core.sv =====
// Channel      Dir  Modport  Beat payload
// -----------  ---  -------  ------------------------------------------
// byte_chan    in   sink     byte_in[7:0]
// result_chan  out  source   code_point[30:0], bad_flag, last_of_run
//
// One byte beat per cycle, back to back, while byte_chan.ready is high. The
// decode state updates in the accept cycle; results land in a 3-entry
// result queue and reach result_chan from its registered head. An ASCII byte
// that breaks an open sequence yields two result beats. byte_chan.ready is
// high while the queue holds at most one entry, taken from registers only.
// rst_n (async, active low) clears the decode state and empties the queue.
// Stalls on result_chan back up through the queue to byte_chan.ready.
module utf8_stream_decoder_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    u8d_byte_if.sink             byte_chan,
    u8d_result_if.source         result_chan
);

    localparam int unsigned CP_W    = u8d_pkg::CP_W;
    localparam int unsigned Q_DEPTH = u8d_pkg::Q_DEPTH;
    localparam int unsigned Q_CNT_W = u8d_pkg::Q_CNT_W;

    // decode state
    logic [CP_W-1:0]                 partial_reg,  partial_next;
    logic [u8d_pkg::REM_W-1:0]       remain_reg,   remain_next;
    logic [u8d_pkg::CLASS_W-1:0]     class_reg,    class_next;

    // result queue, head at entry 0
    u8d_pkg::result_t                q_reg [Q_DEPTH];
    u8d_pkg::result_t                q_next [Q_DEPTH];
    logic [Q_CNT_W-1:0]              cnt_reg, cnt_next;

    logic                            accept;
    logic                            pop;
    logic [u8d_pkg::BYTE_W-1:0]      b;
    logic [1:0]                      n_res;
    u8d_pkg::result_t                res0, res1;

    // lead byte decode
    logic [CP_W-1:0]                 lead_val;
    logic [u8d_pkg::CLASS_W-1:0]     lead_class;
    logic [u8d_pkg::REM_W-1:0]       lead_rem;

    // continuation path
    logic [CP_W-1:0]                 shifted;
    logic [u8d_pkg::REM_W-1:0]       rem_dec;
    logic                            bad_value;

    assign b      = byte_chan.byte_in;
    assign accept = byte_chan.valid && byte_chan.ready;
    assign pop    = result_chan.valid && result_chan.ready;

    assign byte_chan.ready         = (cnt_reg <= Q_CNT_W'(1));
    assign result_chan.valid       = (cnt_reg != '0);
    assign result_chan.code_point  = q_reg[0].code_point;
    assign result_chan.bad_flag    = q_reg[0].bad_flag;
    assign result_chan.last_of_run = q_reg[0].last_of_run;

    always_comb
    begin
        lead_val   = '0;
        lead_class = u8d_pkg::CLASS_6B;
        lead_rem   = 3'd5;
        if (b < 8'd224)
        begin
            lead_class = u8d_pkg::CLASS_2B;
            lead_rem   = 3'd1;
            lead_val   = CP_W'(b[4:0]);
        end
        else if (b < 8'd240)
        begin
            lead_class = u8d_pkg::CLASS_3B;
            lead_rem   = 3'd2;
            lead_val   = CP_W'(b[3:0]);
        end
        else if (b < 8'd248)
        begin
            lead_class = u8d_pkg::CLASS_4B;
            lead_rem   = 3'd3;
            lead_val   = CP_W'(b[2:0]);
        end
        else if (b < 8'd252)
        begin
            lead_class = u8d_pkg::CLASS_5B;
            lead_rem   = 3'd4;
            lead_val   = CP_W'(b[1:0]);
        end
        else
        begin
            lead_val   = CP_W'(b[0]);
        end
    end

    // six new low bits; the old top bits fall off the 31-bit value
    assign shifted   = {partial_reg[CP_W-7:0], b[5:0]};
    assign rem_dec   = remain_reg - 3'd1;
    assign bad_value = (shifted == '0) ||
                       (shifted < u8d_pkg::class_min(class_reg)) ||
                       ((shifted >= u8d_pkg::SURROGATE_LO) &&
                        (shifted <= u8d_pkg::SURROGATE_HI));

    // byte classification and the results it produces
    always_comb
    begin
        partial_next = partial_reg;
        remain_next  = remain_reg;
        class_next   = class_reg;
        n_res        = 2'd0;
        res0         = '{code_point: u8d_pkg::REPLACEMENT, bad_flag: 1'b1,
                         last_of_run: 1'b1};
        res1         = '{code_point: CP_W'(b), bad_flag: 1'b0, last_of_run: 1'b1};

        if (accept)
        begin
            if (b >= 8'd254)
            begin
                // never legal; drop any open sequence
                partial_next = '0;
                remain_next  = '0;
                class_next   = u8d_pkg::CLASS_NONE;
                n_res        = 2'd1;
            end
            else if (b < 8'd128)
            begin
                partial_next = '0;
                remain_next  = '0;
                class_next   = u8d_pkg::CLASS_NONE;
                if (remain_reg != '0)
                begin
                    // broken sequence: replacement first, then the ASCII byte
                    res0.last_of_run = 1'b0;
                    n_res            = 2'd2;
                end
                else
                begin
                    res0  = res1;
                    n_res = 2'd1;
                end
            end
            else if (b < 8'd192)
            begin
                if (remain_reg == '0)
                begin
                    // stray continuation
                    partial_next = '0;
                    class_next   = u8d_pkg::CLASS_NONE;
                    n_res        = 2'd1;
                end
                else if (rem_dec != '0)
                begin
                    partial_next = shifted;
                    remain_next  = rem_dec;
                end
                else
                begin
                    partial_next = '0;
                    remain_next  = '0;
                    class_next   = u8d_pkg::CLASS_NONE;
                    n_res        = 2'd1;
                    if (!bad_value)
                    begin
                        res0.code_point = shifted;
                        res0.bad_flag   = 1'b0;
                    end
                end
            end
            else
            begin
                // lead byte; an interrupted sequence gives a replacement
                partial_next = lead_val;
                remain_next  = lead_rem;
                class_next   = lead_class;
                if (remain_reg != '0)
                begin
                    n_res = 2'd1;
                end
            end
        end
    end

    // queue: pop shifts down, new results append behind what remains
    always_comb
    begin
        logic [Q_CNT_W-1:0] base;
        base = cnt_reg - Q_CNT_W'(pop);
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            if (pop && (i < Q_DEPTH - 1))
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if ((n_res != 2'd0) && (Q_CNT_W'(i) == base))
            begin
                q_next[i] = res0;
            end
            if ((n_res == 2'd2) && (Q_CNT_W'(i) == base + Q_CNT_W'(1)))
            begin
                q_next[i] = res1;
            end
        end
        cnt_next = base + Q_CNT_W'(n_res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= '0;
            class_reg   <= u8d_pkg::CLASS_NONE;
            cnt_reg     <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
            class_reg   <= class_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

// ===== rtl/u8d_checker.sv =====
module u8d_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [u8d_pkg::CP_W-1:0]   code_point,
    input  logic                       bad_flag,
    input  logic                       last_of_run
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point) &&
        $stable(bad_flag) && $stable(last_of_run))
        else $error("result beat changed while stalled");

    a_bad_is_repl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_flag |-> code_point == u8d_pkg::REPLACEMENT)
        else $error("bad beat without replacement value");

    a_no_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_flag |->
        !((code_point >= u8d_pkg::SURROGATE_LO) &&
          (code_point <= u8d_pkg::SURROGATE_HI)))
        else $error("surrogate passed as good value");

    // only the replacement ahead of an ASCII byte is not last of its run
    a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> bad_flag)
        else $error("non-final beat that is not a replacement");

endmodule

bind utf8_stream_decoder_core u8d_checker u_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_chan.valid),
    .out_ready   (result_chan.ready),
    .code_point  (result_chan.code_point),
    .bad_flag    (result_chan.bad_flag),
    .last_of_run (result_chan.last_of_run)
);

// ===== verif/utf8_stream_decoder_core_test.sv =====
`timescale 1ns / 100ps

// Byte-serial UTF-8 (original six-byte form) decoder, checked end to end.
// A 24-beat directed table opens the run. Then come about 1350 random byte
// beats, mostly well-formed sequences with random content and some corner
// values. A smaller share is truncated sequences and raw noise. Every
// accepted byte runs through a local decoder model. Every result beat is
// compared against the oldest expectation.
module utf8_stream_decoder_core_test;

    localparam int STUCK_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES  = 20;    // settle time after the last result
    localparam int PHASE_BYTES   = 330;   // random byte beats per idling phase
    localparam int SQUEEZE_BYTES = 40;    // byte beats offered into the hold-off
    localparam int REPORT_LIMIT  = 10;

    localparam logic TYPED     = 1'b1;    // expected result written in the row
    localparam logic PREDICTED = 1'b0;    // expected result from decode_byte

    typedef struct packed {
        logic [u8d_pkg::BYTE_W-1:0] data;
        logic                       typed;
        logic [u8d_pkg::CP_W-1:0]   cp;
        logic                       bad;
    } stim_row_t;

    // Directed table: ASCII extremes, stray continuation, illegal byte 254,
    // 2-byte good and zero value, surrogate, ASCII cutting into a 3-byte
    // sequence (two beats out), lead byte cutting into a 4-byte sequence,
    // largest 6-byte value, and byte 255 dropping an open 5-byte sequence.
    localparam stim_row_t DIRECTED_ROWS [0:23] = '{
        '{8'h00, TYPED,     31'd0,                   1'b0},
        '{8'h7F, TYPED,     31'd127,                 1'b0},
        '{8'h80, TYPED,     u8d_pkg::REPLACEMENT,    1'b1},
        '{8'hFE, TYPED,     u8d_pkg::REPLACEMENT,    1'b1},
        '{8'hC2, PREDICTED, 31'd0,                   1'b0},
        '{8'h80, PREDICTED, 31'd0,                   1'b0},
        '{8'hC0, PREDICTED, 31'd0,                   1'b0},
        '{8'h80, PREDICTED, 31'd0,                   1'b0},
        '{8'hED, PREDICTED, 31'd0,                   1'b0},
        '{8'hA0, PREDICTED, 31'd0,                   1'b0},
        '{8'h80, PREDICTED, 31'd0,                   1'b0},
        '{8'hE0, PREDICTED, 31'd0,                   1'b0},
        '{8'h41, PREDICTED, 31'd0,                   1'b0},
        '{8'hF0, PREDICTED, 31'd0,                   1'b0},
        '{8'hC3, PREDICTED, 31'd0,                   1'b0},
        '{8'hA9, PREDICTED, 31'd0,                   1'b0},
        '{8'hFD, PREDICTED, 31'd0,                   1'b0},
        '{8'hBF, PREDICTED, 31'd0,                   1'b0},
        '{8'hBF, PREDICTED, 31'd0,                   1'b0},
        '{8'hBF, PREDICTED, 31'd0,                   1'b0},
        '{8'hBF, PREDICTED, 31'd0,                   1'b0},
        '{8'hBF, TYPED,     31'h7FFFFFFF,            1'b0},
        '{8'hF8, PREDICTED, 31'd0,                   1'b0},
        '{8'hFF, TYPED,     u8d_pkg::REPLACEMENT,    1'b1}
    };

    localparam int PHASE_IDLE  [0:3] = '{0, 62, 0, 27};
    localparam int PHASE_STALL [0:3] = '{0, 0, 62, 27};

    logic clk;
    logic rst_n;

    u8d_byte_if   byte_chan ();
    u8d_result_if result_chan ();

    utf8_stream_decoder_core DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_chan),
        .result_chan (result_chan)
    );

    // decoder model state
    logic [u8d_pkg::CP_W-1:0]    seq_acc;
    logic [u8d_pkg::REM_W-1:0]   seq_left;
    logic [u8d_pkg::CLASS_W-1:0] seq_cls;

    // result beats caused by the last decoded byte
    u8d_pkg::result_t step_out [0:1];
    int               step_cnt;

    u8d_pkg::result_t awaited_results [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;

    int stuck_cycles      = 0;
    int mismatches        = 0;
    int bytes_sent        = 0;
    int results_checked   = 0;
    int replacements_seen = 0;
    int split_bytes       = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Smallest value a sequence of the given class may carry; anything
    // lower is an overlong form.
    function automatic logic [u8d_pkg::CP_W-1:0] legal_floor(
        input logic [u8d_pkg::CLASS_W-1:0] cls);
        case (cls)
            u8d_pkg::CLASS_2B: return 31'd128;
            u8d_pkg::CLASS_3B: return 31'd2048;
            u8d_pkg::CLASS_4B: return 31'd65536;
            u8d_pkg::CLASS_5B: return 31'd2097152;
            u8d_pkg::CLASS_6B: return 31'd67108864;
            default:           return '0;
        endcase
    endfunction

    function automatic void go_idle();
        seq_acc  = '0;
        seq_left = '0;
        seq_cls  = u8d_pkg::CLASS_NONE;
    endfunction

    function automatic void emit(input logic [u8d_pkg::CP_W-1:0] cp, input logic bad,
                                 input logic last);
        step_out[step_cnt] = '{code_point: cp, bad_flag: bad, last_of_run: last};
        step_cnt++;
    endfunction

    function automatic void decode_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
        logic [u8d_pkg::CP_W-1:0] v;
        logic [u8d_pkg::CP_W-1:0] floor_v;
        step_cnt = 0;
        if (b >= 8'd254)
        begin
            // never legal; drops whatever was open
            go_idle();
            emit(u8d_pkg::REPLACEMENT, 1'b1, 1'b1);
        end
        else if (b < 8'h80)
        begin
            // ASCII breaking into a sequence: replacement beat first
            if (seq_left != '0)
            begin
                go_idle();
                emit(u8d_pkg::REPLACEMENT, 1'b1, 1'b0);
            end
            emit({23'd0, b}, 1'b0, 1'b1);
        end
        else if (b < 8'hC0)
        begin
            if (seq_left == '0)
            begin
                // stray continuation
                emit(u8d_pkg::REPLACEMENT, 1'b1, 1'b1);
            end
            else
            begin
                seq_acc  = {seq_acc[u8d_pkg::CP_W-7:0], b[5:0]};
                seq_left = seq_left - 1'b1;
                if (seq_left == '0)
                begin
                    v       = seq_acc;
                    floor_v = legal_floor(seq_cls);
                    go_idle();
                    if (v == '0 || v < floor_v ||
                        (v >= u8d_pkg::SURROGATE_LO && v <= u8d_pkg::SURROGATE_HI))
                        emit(u8d_pkg::REPLACEMENT, 1'b1, 1'b1);
                    else
                        emit(v, 1'b0, 1'b1);
                end
            end
        end
        else
        begin
            // lead byte; an open sequence is cut off with a replacement
            if (seq_left != '0)
                emit(u8d_pkg::REPLACEMENT, 1'b1, 1'b1);
            if (b < 8'hE0)
            begin
                seq_cls  = u8d_pkg::CLASS_2B;
                seq_acc  = {26'd0, b[4:0]};
                seq_left = 3'd1;
            end
            else if (b < 8'hF0)
            begin
                seq_cls  = u8d_pkg::CLASS_3B;
                seq_acc  = {27'd0, b[3:0]};
                seq_left = 3'd2;
            end
            else if (b < 8'hF8)
            begin
                seq_cls  = u8d_pkg::CLASS_4B;
                seq_acc  = {28'd0, b[2:0]};
                seq_left = 3'd3;
            end
            else if (b < 8'hFC)
            begin
                seq_cls  = u8d_pkg::CLASS_5B;
                seq_acc  = {29'd0, b[1:0]};
                seq_left = 3'd4;
            end
            else
            begin
                seq_cls  = u8d_pkg::CLASS_6B;
                seq_acc  = {30'd0, b[0]};
                seq_left = 3'd5;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------

    // Offers one byte beat and returns in the step of its acceptance.
    // valid is left high on return, so a following beat never lowers and
    // raises it within one step.
    task automatic send_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_chan.valid <= 1'b0;
            @(posedge clk);
        end
        byte_chan.valid   <= 1'b1;
        byte_chan.byte_in <= b;
        do @(posedge clk); while (!byte_chan.ready);
        bytes_sent++;
    endtask

    task automatic apply_byte(input logic [u8d_pkg::BYTE_W-1:0] b);
        send_byte(b);
        decode_byte(b);
        for (int i = 0; i < step_cnt; i++)
            awaited_results.push_back(step_out[i]);
        if (step_cnt == 2)
            split_bytes++;
    endtask

    // One random unit: an ASCII byte, a sequence of 2..6 bytes (sometimes
    // cut short so the next unit interrupts it), or a raw noise byte.
    task automatic send_random_unit();
        int                         pick;
        int                         seq_len;
        int                         conts;
        int                         r;
        logic [u8d_pkg::CP_W-1:0]   v;
        logic [u8d_pkg::BYTE_W-1:0] lead_mask;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            apply_byte(8'($urandom_range(127)));
        end
        else if (pick < 88)
        begin
            r = $urandom_range(9);
            seq_len = (r < 3) ? 2 : (r < 6) ? 3 : (r < 8) ? 4 : (r == 8) ? 5 : 6;
            v = 31'($urandom);
            if ($urandom_range(9) == 0)
            begin
                // corner values: class floors, class tops, surrogate bounds
                case ($urandom_range(6))
                    0:       v = legal_floor(u8d_pkg::CLASS_W'(seq_len - 1));
                    1:       v = legal_floor(u8d_pkg::CLASS_W'(seq_len - 1)) - 1'b1;
                    2:       v = (31'd1 << (5 * seq_len + 1)) - 1'b1;
                    3:       v = u8d_pkg::SURROGATE_LO;
                    4:       v = u8d_pkg::SURROGATE_HI;
                    5:       v = u8d_pkg::SURROGATE_LO - 1'b1;
                    default: v = u8d_pkg::SURROGATE_HI + 1'b1;
                endcase
            end
            // 80..87 gives a truncated sequence
            conts = (pick >= 80) ? $urandom_range(seq_len - 2) : seq_len - 1;
            lead_mask = 8'hFF >> (seq_len + 1);
            apply_byte(((8'hFF << (8 - seq_len)) & 8'hFF) |
                       (8'(v >> (6 * (seq_len - 1))) & lead_mask));
            for (int k = seq_len - 2; k >= seq_len - 1 - conts; k--)
                apply_byte(8'h80 | (8'(v >> (6 * k)) & 8'h3F));
        end
        else
        begin
            apply_byte(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        result_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_chan.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                result_chan.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("ERROR: %s", msg);
    endfunction

    // Result checker and activity tracking, sampled at the rising edge.
    always @(posedge clk)
    begin : result_check
        u8d_pkg::result_t want;
        u8d_pkg::result_t got;
        if (rst_n)
        begin
            if ((byte_chan.valid && byte_chan.ready) ||
                (result_chan.valid && result_chan.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;

            if (result_chan.valid && result_chan.ready)
            begin
                got = '{code_point:  result_chan.code_point,
                        bad_flag:    result_chan.bad_flag,
                        last_of_run: result_chan.last_of_run};
                results_checked++;
                if (got.bad_flag)
                    replacements_seen++;
                if (awaited_results.size() == 0)
                begin
                    flag_error($sformatf("unexpected result beat cp=%0d bad=%0b last=%0b",
                                         got.code_point, got.bad_flag, got.last_of_run));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.code_point !== want.code_point ||
                        got.bad_flag !== want.bad_flag ||
                        got.last_of_run !== want.last_of_run)
                        flag_error($sformatf({"result %0d: expected cp=%0d bad=%0b last=%0b,",
                                              " got cp=%0d bad=%0b last=%0b"},
                                             results_checked, want.code_point,
                                             want.bad_flag, want.last_of_run,
                                             got.code_point, got.bad_flag,
                                             got.last_of_run));
                end
            end
        end
    end

    // Watchdog: no beat on either channel for too long means a hang.
    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("no beat for %0d cycles, %0d results still expected",
                 STUCK_LIMIT, awaited_results.size());
        $display("utf8_stream_decoder_core regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase_start;
        go_idle();
        rst_n             <= 1'b0;
        byte_chan.valid   <= 1'b0;
        byte_chan.byte_in <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling on either side
        for (int r = 0; r < $size(DIRECTED_ROWS); r++)
        begin
            if (DIRECTED_ROWS[r].typed)
            begin
                send_byte(DIRECTED_ROWS[r].data);
                decode_byte(DIRECTED_ROWS[r].data);  // keeps the model state in step
                awaited_results.push_back('{code_point:  DIRECTED_ROWS[r].cp,
                                            bad_flag:    DIRECTED_ROWS[r].bad,
                                            last_of_run: 1'b1});
            end
            else
            begin
                apply_byte(DIRECTED_ROWS[r].data);
            end
        end

        // random traffic under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = PHASE_IDLE[p];
            stall_pct     = PHASE_STALL[p];
            phase_start   = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_unit();
        end

        // long receiver hold-off while bytes keep coming: the result queue
        // fills and byte_chan.ready must drop until the hold ends
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b1;
        phase_start   = bytes_sent;
        while (bytes_sent - phase_start < SQUEEZE_BYTES)
            send_random_unit();

        byte_chan.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d byte beats and %0d result beats, %0d of them replacements",
                 bytes_sent, results_checked, replacements_seen);
        $display("%0d bytes gave two beats; %0d mismatches", split_bytes, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("utf8_stream_decoder_core regression: pass");
        else
            $display("utf8_stream_decoder_core regression: fail");
        $finish;
    end

endmodule

// ===== utf8_stream_decoder_core.f =====
rtl/u8d_pkg.sv
rtl/u8d_if.sv
rtl/utf8_stream_decoder_core.sv
rtl/u8d_checker.sv
verif/utf8_stream_decoder_core_test.sv
